/* sv/kbpf_pkg.sv */
package kbpf_pkg;

  // Input opcodes; the spare code runs a keypoint test as well
  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_STORE    = 2'd1,
    OP_TEST     = 2'd2,
    OP_TEST_ALT = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_KEPT    = 3'd0,
    ST_BORDER  = 3'd1,
    ST_CLOSE   = 3'd2,
    ST_STORED  = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEARED = 3'd5
  } status_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_BORDER_MARGIN = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd2;
  localparam logic [1:0] CFG_MIN_DISTANCE  = 2'd3;

  // Register reset values
  localparam logic [10:0] BORDER_MARGIN_RST = 11'd8;
  localparam logic [12:0] IMAGE_WIDTH_RST   = 13'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST  = 13'd480;
  localparam logic [15:0] MIN_DISTANCE_RST  = 16'd160;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_RESP
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    clear;
    logic    store;
    logic    scan_start;
    logic    scan;
    logic    set_st;
    status_e st;
    logic    emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  op;
    logic border_rej;
    logic tbl_empty;
    logic tbl_full;
    logic issue_done;
    logic pipe_busy;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

/* sv/kbpf_if.sv */
// Keypoint command channel
interface kbpf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;

  modport source (output valid, output opcode, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input opcode, input coord_x, input coord_y, output ready);
endinterface

// Result channel
interface kbpf_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               keep;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;

  modport source (output valid, output status, output keep, output out_x, output out_y,
                  input ready);
  modport sink   (input valid, input status, input keep, input out_x, input out_y,
                  output ready);
endinterface

// Configuration write channel
interface kbpf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/kbpf_ctrl.sv */
module kbpf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kbpf_pkg::stat_t stat_i,
  output kbpf_pkg::cmd_t  cmd_o
);
  import kbpf_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.st   = ST_KEPT;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.set_st = 1'b1;
        state_d      = S_RESP;
        case (stat_i.op)
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            cmd_o.st    = ST_CLEARED;
          end
          OP_STORE: begin
            if (stat_i.tbl_full) begin
              cmd_o.st = ST_FULL;
            end else begin
              cmd_o.store = 1'b1;
              cmd_o.st    = ST_STORED;
            end
          end
          default: begin
            if (stat_i.border_rej) begin
              cmd_o.st = ST_BORDER;
            end else if (stat_i.tbl_empty) begin
              cmd_o.st = ST_KEPT;
            end else begin
              cmd_o.set_st     = 1'b0;
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_CLOSE;
          state_d      = S_RESP;
        end else if (stat_i.issue_done && !stat_i.pipe_busy) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_KEPT;
          state_d      = S_RESP;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Emit only into a free output register, and only after a decision was made
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free) else $error("emit into busy output");
  a_resp_from: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) && !$past(state_q == S_RESP) |->
      ($past(state_q == S_EVAL) || $past(state_q == S_SCAN)))
    else $error("response state entered without evaluation");
  a_scan_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && !stat_i.hit && !(stat_i.issue_done && !stat_i.pipe_busy)
      |=> (state_q == S_SCAN)) else $error("scan left early");

endmodule

/* sv/kbpf_dp.sv */
module kbpf_dp #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kbpf_pkg::cmd_t     cmd_i,
  output kbpf_pkg::stat_t    stat_o,
  input  logic [1:0]         in_opcode_i,
  input  logic signed [15:0] in_x_i,
  input  logic signed [15:0] in_y_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         out_status_o,
  output logic               out_keep_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o
);
  import kbpf_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  // Configuration registers
  logic [10:0] border_margin_q;
  logic [12:0] image_width_q;
  logic [12:0] image_height_q;
  logic [15:0] min_distance_q;
  logic [31:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_margin_q <= BORDER_MARGIN_RST;
      image_width_q   <= IMAGE_WIDTH_RST;
      image_height_q  <= IMAGE_HEIGHT_RST;
      min_distance_q  <= MIN_DISTANCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BORDER_MARGIN: border_margin_q <= cfg_data_i[10:0];
        CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data_i[12:0];
        CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data_i[12:0];
        CFG_MIN_DISTANCE:  min_distance_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Squared distance limit, refreshed every cycle
  always_ff @(posedge clk_i) begin
    lim_q <= min_distance_q * min_distance_q;
  end

  // Captured item
  op_e                op_q;
  logic signed [15:0] x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(in_opcode_i);
      x_q  <= in_x_i;
      y_q  <= in_y_i;
    end
  end

  // Border test in 12.4 units
  logic [11:0]        margin_px;
  logic [15:0]        edge_fx;
  logic signed [18:0] e_s, xmax_s, ymax_s, xs, ys;
  logic               border_rej;

  always_comb begin
    margin_px  = {1'b0, border_margin_q} + 12'd1;
    edge_fx    = {margin_px, 4'b0000};
    e_s        = $signed({3'b000, edge_fx});
    xmax_s     = $signed({2'b00, image_width_q, 4'b0000}) - e_s;
    ymax_s     = $signed({2'b00, image_height_q, 4'b0000}) - e_s;
    xs         = 19'(x_q);
    ys         = 19'(y_q);
    border_rej = (xs < e_s) || (ys < e_s) || (xs > xmax_s) || (ys > ymax_s);
  end

  // Point table and count
  logic [15:0]      mem_x [MAX_POINTS];
  logic [15:0]      mem_y [MAX_POINTS];
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.store) begin
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_x[count_q[IDX_W-1:0]] <= x_q;
      mem_y[count_q[IDX_W-1:0]] <= y_q;
    end
  end

  // Scan pipeline: read, square, compare
  logic [CNT_W-1:0]   idx_q;
  logic               issue;
  logic               v1_q, v2_q;
  logic signed [15:0] rx_q, ry_q;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic [31:0]        sqx_q, sqy_q;
  logic [32:0]        dist_sq;
  logic               hit;

  assign issue = cmd_i.scan && (idx_q != count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else if (cmd_i.scan_start) begin
      idx_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (issue) begin
        idx_q <= idx_q + 1'b1;
      end
      v1_q <= issue;
      v2_q <= cmd_i.scan && v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rx_q <= mem_x[idx_q[IDX_W-1:0]];
      ry_q <= mem_y[idx_q[IDX_W-1:0]];
    end
  end

  always_comb begin
    dx      = 17'(x_q) - 17'(rx_q);
    dy      = 17'(y_q) - 17'(ry_q);
    adx     = dx[16] ? 17'(-dx) : dx;
    ady     = dy[16] ? 17'(-dy) : dy;
    dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
    hit     = v2_q && (dist_sq < {1'b0, lim_q});
  end

  always_ff @(posedge clk_i) begin
    sqx_q <= adx[15:0] * adx[15:0];
    sqy_q <= ady[15:0] * ady[15:0];
  end

  // Held decision
  status_e st_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_st) begin
      st_q <= cmd_i.st;
    end
  end

  // Output register
  logic               out_valid_q;
  status_e            out_st_q;
  logic signed [15:0] out_x_q, out_y_q;
  logic               out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_st_q <= st_q;
      out_x_q  <= x_q;
      out_y_q  <= y_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_st_q;
  assign out_keep_o   = (out_st_q == ST_KEPT);
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;

  // Status to the controller
  always_comb begin
    stat_o            = '0;
    stat_o.op         = op_q;
    stat_o.border_rej = border_rej;
    stat_o.tbl_empty  = (count_q == '0);
    stat_o.tbl_full   = (count_q == MAX_CNT);
    stat_o.issue_done = (idx_q == count_q);
    stat_o.pipe_busy  = v1_q || v2_q;
    stat_o.hit        = hit;
    stat_o.out_free   = out_free;
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT) else $error("point count beyond table depth");
  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> (count_q != MAX_CNT)) else $error("store into full table");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (idx_q <= count_q)) else $error("scan index past count");
  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q)) else $error("compare stage without read stage");

endmodule

/* sv/keypoint_border_and_proximity_filter_top.sv */
// Keypoint border and proximity filter. Each command transfer yields exactly one
// result transfer, in order. Clear, store, a border reject and a test against an
// empty table pass through the take, decide and respond states from one command
// transfer to the next. A test against a non-empty table walks the table between
// decide and respond: one read of the point memory and one squared-distance
// compare per cycle through a three-stage read/square/compare pipeline, which is
// flushed before a kept result. A proximity hit on any stored point ends the walk
// early. The finished result waits in the respond state while the output
// register is busy. A new command is taken while the previous result still waits
// in the output register. Configuration writes are accepted every cycle and should
// be issued while the block is idle.
module keypoint_border_and_proximity_filter_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kbpf_in_if.sink    in_i,
  kbpf_out_if.source out_o,
  kbpf_cfg_if.sink   cfg_i
);
  import kbpf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // Sequencer
  kbpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table, border and distance datapath
  kbpf_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_opcode_i  (in_i.opcode),
    .in_x_i       (in_i.coord_x),
    .in_y_i       (in_i.coord_y),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_keep_o   (out_o.keep),
    .out_x_o      (out_o.out_x),
    .out_y_o      (out_o.out_y)
  );

endmodule
